// ===== sv/rsmp_pkg.sv =====
// Shared types and constants for the random sample without replacement unit.
// Used by rsmp_cell and random_sample_without_replacement_unit; no dependencies.
package rsmp_pkg;

    localparam int MAX_TOTAL  = 1024;
    localparam int MAX_SELECT = 64;

    // scaling divides by 2^31-1, which the folding divider in the top level relies on
    localparam logic [31:0] RAND_LIMIT = 32'h7FFF_FFFF;

    localparam int IDX_W     = $clog2(MAX_TOTAL);
    localparam int TOTAL_W   = 11;
    localparam int SEL_W     = 7;
    localparam int RAND_W    = 31;
    localparam int PROD_W    = TOTAL_W + RAND_W;
    localparam int TAG_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOTAL_COUNT  = 2'd0,
        REG_SELECT_COUNT = 2'd1
    } cfg_reg_t;

    typedef logic [IDX_W-1:0] idx_t;

    // command to every cell of the sorting chain
    typedef struct packed {
        logic insert;
        logic shift;
        logic flush;
    } cell_ctrl_t;

    // what a cell shows its neighbors
    typedef struct packed {
        idx_t value;
        logic valid;
        logic gt;
    } cell_link_t;

    // one permutation memory word: epoch tag and stored value
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        idx_t             value;
    } perm_entry_t;

endpackage

// ===== sv/rsmp_cell.sv =====
// One cell of the sorted pick chain: holds one index, inserts in order, shifts out.
// Depends on rsmp_pkg.
module rsmp_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  rsmp_pkg::cell_ctrl_t ctrl,
    input  rsmp_pkg::idx_t      ins_value,
    input  rsmp_pkg::cell_link_t from_left,
    input  rsmp_pkg::cell_link_t from_right,
    output rsmp_pkg::cell_link_t link
);

    rsmp_pkg::idx_t value_reg;
    rsmp_pkg::idx_t value_next;
    logic           valid_reg;
    logic           valid_next;
    logic           gt;

    // an empty cell counts as larger than anything
    assign gt = !valid_reg || (value_reg > ins_value);

    // insertion takes the left neighbor when it also moves up, else the new value
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.flush)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            value_next = from_right.value;
            valid_next = from_right.valid;
        end
        else if (ctrl.insert)
        begin
            if (gt)
            begin
                value_next = from_left.gt ? from_left.value : ins_value;
            end
            valid_next = valid_reg | from_left.valid;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.value = value_reg;
    assign link.valid = valid_reg;
    assign link.gt    = gt;

endmodule

// ===== sv/random_sample_without_replacement_unit.sv =====
// Top level: partial Fisher-Yates sampler with permutation memory and sorted pick chain.
// Depends on rsmp_pkg and rsmp_cell.
//
//  channel   ports                                   transfer
//  input     start, busy, random_value               start high while busy low
//  config    cfg_we, cfg_index, cfg_data             cfg_we high
//  result    pick_strobe, picked_index, last_pick    pick_strobe high, one cycle
//
// Each draw holds busy after its transfer while it steps through multiply, fold divide, read j,
// write i and write j, so a new draw transfer is taken only once the last one is through.
// After the final draw the picks leave one per cycle, ascending.
// After reset a clearing pass over all MAX_TOTAL (1024) memory entries tags each one;
// it repeats after every 255th finished selection or register write, as the epoch wraps.
// Results are never held back; busy stays high from a transfer until it is done.
module random_sample_without_replacement_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [rsmp_pkg::RAND_W-1:0]     random_value,
    input  logic                            cfg_we,
    input  logic [rsmp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rsmp_pkg::CFG_W-1:0]      cfg_data,
    output logic                            pick_strobe,
    output logic [rsmp_pkg::IDX_W-1:0]      picked_index,
    output logic                            last_pick
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_CLEAR = 8'b0000_0010,
        ST_MUL   = 8'b0000_0100,
        ST_DIV   = 8'b0000_1000,
        ST_RDJ   = 8'b0001_0000,
        ST_WRI   = 8'b0010_0000,
        ST_WRJ   = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    localparam int QUO_W = rsmp_pkg::TOTAL_W + 1;

    state_t                              state_reg, state_next;
    logic [rsmp_pkg::TOTAL_W-1:0]        total_count_reg, total_count_next;
    logic [rsmp_pkg::SEL_W-1:0]          select_count_reg, select_count_next;
    logic [rsmp_pkg::SEL_W-1:0]          draws_reg, draws_next;
    logic [rsmp_pkg::TAG_W-1:0]          epoch_reg, epoch_next;
    rsmp_pkg::idx_t                      clear_ptr_reg, clear_ptr_next;

    logic [rsmp_pkg::RAND_W-1:0]         rand_reg, rand_next;
    rsmp_pkg::idx_t                      i_reg, i_next;
    logic [rsmp_pkg::TOTAL_W-1:0]        i1_reg, i1_next;
    logic [rsmp_pkg::PROD_W-1:0]         prod_reg, prod_next;
    rsmp_pkg::idx_t                      j_reg, j_next;
    rsmp_pkg::idx_t                      vi_reg, vi_next;

    logic [rsmp_pkg::TOTAL_W-1:0]        eff_total;
    logic [rsmp_pkg::SEL_W-1:0]          eff_select;
    logic [rsmp_pkg::SEL_W-1:0]          sel_nz;
    logic [rsmp_pkg::TOTAL_W-1:0]        pos_i;

    logic [rsmp_pkg::TOTAL_W-1:0]        fold_hi;
    logic [31:0]                         fold_sum;
    logic [QUO_W-1:0]                    quotient;
    rsmp_pkg::idx_t                      j_calc;

    rsmp_pkg::perm_entry_t               mem [rsmp_pkg::MAX_TOTAL];
    rsmp_pkg::perm_entry_t               rdata_reg;
    rsmp_pkg::perm_entry_t               mem_wdata;
    rsmp_pkg::idx_t                      mem_addr;
    logic                                mem_we;
    rsmp_pkg::idx_t                      rd_value;
    rsmp_pkg::idx_t                      rd_pos;

    rsmp_pkg::cell_ctrl_t                cell_ctrl;
    rsmp_pkg::idx_t                      vj;
    rsmp_pkg::cell_link_t                links [rsmp_pkg::MAX_SELECT];

    logic                                accept;
    logic                                restart;

    // effective register values
    always_comb
    begin
        eff_total = total_count_reg;
        if (total_count_reg == '0)
        begin
            eff_total = rsmp_pkg::TOTAL_W'(1);
        end
        else if (total_count_reg > rsmp_pkg::TOTAL_W'(rsmp_pkg::MAX_TOTAL))
        begin
            eff_total = rsmp_pkg::TOTAL_W'(rsmp_pkg::MAX_TOTAL);
        end

        sel_nz = (select_count_reg == '0) ? rsmp_pkg::SEL_W'(1) : select_count_reg;
        eff_select = sel_nz;
        if (rsmp_pkg::TOTAL_W'(sel_nz) > eff_total)
        begin
            eff_select = eff_total[rsmp_pkg::SEL_W-1:0];
        end
        if (eff_select > rsmp_pkg::SEL_W'(rsmp_pkg::MAX_SELECT))
        begin
            eff_select = rsmp_pkg::SEL_W'(rsmp_pkg::MAX_SELECT);
        end
    end

    // position of this draw
    assign pos_i = eff_total - rsmp_pkg::TOTAL_W'(draws_reg) - rsmp_pkg::TOTAL_W'(1);

    // divide by 2^31-1: x = hi*2^31 + lo gives hi plus one when hi+lo reaches the limit
    assign fold_hi  = prod_reg[rsmp_pkg::PROD_W-1:rsmp_pkg::RAND_W];
    assign fold_sum = 32'(fold_hi) + 32'(prod_reg[rsmp_pkg::RAND_W-1:0]);
    assign quotient = QUO_W'(fold_hi) + QUO_W'(fold_sum >= rsmp_pkg::RAND_LIMIT);
    assign j_calc   = (quotient > QUO_W'(i_reg)) ? i_reg : quotient[rsmp_pkg::IDX_W-1:0];

    // entry read back: stale tag means the entry still holds its own position
    assign rd_pos   = state_reg == ST_DIV ? i_reg : j_reg;
    assign rd_value = (rdata_reg.tag == epoch_reg) ? rdata_reg.value : rd_pos;
    assign vj       = rd_value;

    assign accept  = start && !busy;
    assign busy    = state_reg != ST_IDLE;
    assign restart = cfg_we || (state_reg == ST_EMIT && last_pick);

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        total_count_next  = total_count_reg;
        select_count_next = select_count_reg;
        draws_next        = draws_reg;
        epoch_next        = epoch_reg;
        clear_ptr_next    = clear_ptr_reg;
        rand_next         = rand_reg;
        i_next            = i_reg;
        i1_next           = i1_reg;
        prod_next         = prod_reg;
        j_next            = j_reg;
        vi_next           = vi_reg;
        mem_we            = 1'b0;
        mem_addr          = i_reg;
        mem_wdata         = '{tag: epoch_reg, value: vj};
        cell_ctrl         = '{insert: 1'b0, shift: 1'b0, flush: 1'b0};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rand_next  = random_value;
                    i_next     = pos_i[rsmp_pkg::IDX_W-1:0];
                    i1_next    = pos_i + rsmp_pkg::TOTAL_W'(1);
                    state_next = ST_MUL;
                end
            end
            ST_CLEAR:
            begin
                mem_we         = 1'b1;
                mem_addr       = clear_ptr_reg;
                mem_wdata      = '{tag: '0, value: '0};
                clear_ptr_next = clear_ptr_reg + rsmp_pkg::IDX_W'(1);
                if (clear_ptr_reg == rsmp_pkg::IDX_W'(rsmp_pkg::MAX_TOTAL - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                // read entry i while the scale product forms
                mem_addr   = i_reg;
                prod_next  = rsmp_pkg::PROD_W'(i1_reg) * rsmp_pkg::PROD_W'(rand_reg);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                vi_next    = rd_value;
                j_next     = j_calc;
                state_next = ST_RDJ;
            end
            ST_RDJ:
            begin
                mem_addr   = j_reg;
                state_next = ST_WRI;
            end
            ST_WRI:
            begin
                mem_we           = 1'b1;
                mem_addr         = i_reg;
                mem_wdata        = '{tag: epoch_reg, value: vj};
                cell_ctrl.insert = 1'b1;
                draws_next       = draws_reg + rsmp_pkg::SEL_W'(1);
                state_next       = ST_WRJ;
            end
            ST_WRJ:
            begin
                mem_we     = 1'b1;
                mem_addr   = j_reg;
                mem_wdata  = '{tag: epoch_reg, value: vi_reg};
                state_next = (draws_reg == eff_select) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                cell_ctrl.shift = 1'b1;
                if (last_pick)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // configuration writes; an unused index leaves everything as it is
        if (cfg_we)
        begin
            unique case (cfg_index)
                rsmp_pkg::REG_TOTAL_COUNT:
                begin
                    total_count_next = cfg_data[rsmp_pkg::TOTAL_W-1:0];
                    cell_ctrl.flush  = 1'b1;
                end
                rsmp_pkg::REG_SELECT_COUNT:
                begin
                    select_count_next = cfg_data[rsmp_pkg::SEL_W-1:0];
                    cell_ctrl.flush   = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        // new selection: fresh epoch, or a clearing pass when the tag wraps
        if (restart && !(cfg_we && cfg_index > rsmp_pkg::CFG_IDX_W'(rsmp_pkg::REG_SELECT_COUNT)))
        begin
            draws_next = '0;
            if (epoch_reg == '1)
            begin
                epoch_next     = rsmp_pkg::TAG_W'(1);
                clear_ptr_next = '0;
                state_next     = ST_CLEAR;
            end
            else
            begin
                epoch_next = epoch_reg + rsmp_pkg::TAG_W'(1);
            end
        end
    end

    // permutation memory, one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            total_count_reg  <= rsmp_pkg::TOTAL_W'(rsmp_pkg::MAX_TOTAL);
            select_count_reg <= rsmp_pkg::SEL_W'(1);
            draws_reg        <= '0;
            epoch_reg        <= rsmp_pkg::TAG_W'(1);
            clear_ptr_reg    <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            total_count_reg  <= total_count_next;
            select_count_reg <= select_count_next;
            draws_reg        <= draws_next;
            epoch_reg        <= epoch_next;
            clear_ptr_reg    <= clear_ptr_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rand_reg <= rand_next;
        i_reg    <= i_next;
        i1_reg   <= i1_next;
        prod_reg <= prod_next;
        j_reg    <= j_next;
        vi_reg   <= vi_next;
    end

    // sorted pick chain
    for (genvar k = 0; k < rsmp_pkg::MAX_SELECT; k++)
    begin : g_chain
        rsmp_pkg::cell_link_t left_in;
        rsmp_pkg::cell_link_t right_in;

        if (k == 0)
        begin : g_first
            assign left_in = '{value: '0, valid: 1'b1, gt: 1'b0};
        end
        else
        begin : g_mid_left
            assign left_in = links[k-1];
        end

        if (k == rsmp_pkg::MAX_SELECT - 1)
        begin : g_last
            assign right_in = '{value: '0, valid: 1'b0, gt: 1'b1};
        end
        else
        begin : g_mid_right
            assign right_in = links[k+1];
        end

        rsmp_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .ins_value  (vj),
            .from_left  (left_in),
            .from_right (right_in),
            .link       (links[k])
        );
    end

    // result transfer from the head of the chain
    assign pick_strobe  = state_reg == ST_EMIT;
    assign picked_index = links[0].value;
    assign last_pick    = pick_strobe && !g_chain[0].right_in.valid;

endmodule

// ===== tb/sv/random_sample_without_replacement_unit_test.sv =====
// Testbench for random_sample_without_replacement_unit: directed and random draws,
// register changes between phases, every pick checked against a built-in predictor.
// Depends on rsmp_pkg and the unit itself.
module random_sample_without_replacement_unit_test;

    import rsmp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;
    localparam logic [RAND_W-1:0]    RAND_TOP     = RAND_W'(RAND_LIMIT);
    localparam int                   QUIET_LIMIT  = 6000;
    localparam int                   RANDOM_DRAWS = 140;

    typedef struct {
        idx_t index;
        bit   last;
    } pick_t;

    // shuffle predictor and queue of picks still to come
    class sample_tracker;
        logic [TOTAL_W-1:0] total_reg;
        logic [SEL_W-1:0]   select_reg;
        idx_t               perm_value[MAX_TOTAL];
        bit                 entry_set[MAX_TOTAL];
        idx_t               sorted_so_far[MAX_SELECT];
        int unsigned        draws_done;
        pick_t              expected_picks[$];
        int                 errors;

        function new();
            total_reg  = TOTAL_W'(1024);
            select_reg = SEL_W'(1);
            errors     = 0;
            clear_draws();
        endfunction

        function void clear_draws();
            foreach (entry_set[p])
                entry_set[p] = 1'b0;
            draws_done = 0;
        endfunction

        function int unsigned candidates();
            int unsigned t;
            t = total_reg;
            if (t == 0)
                t = 1;
            if (t > MAX_TOTAL)
                t = MAX_TOTAL;
            return t;
        endfunction

        function int unsigned picks_per_selection();
            int unsigned t;
            int unsigned s;
            t = candidates();
            s = select_reg;
            if (s == 0)
                s = 1;
            if (s > t)
                s = t;
            if (s > MAX_SELECT)
                s = MAX_SELECT;
            return s;
        endfunction

        function int pending();
            return expected_picks.size();
        endfunction

        // any write to a real register abandons the selection in progress
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_TOTAL_COUNT)
            begin
                total_reg = data[TOTAL_W-1:0];
                clear_draws();
            end
            else if (idx == REG_SELECT_COUNT)
            begin
                select_reg = data[SEL_W-1:0];
                clear_draws();
            end
        endfunction

        // one swap step; the full sorted selection is queued after the last draw
        function void note_draw(logic [RAND_W-1:0] word);
            int unsigned       s;
            int unsigned       i;
            int unsigned       j;
            int unsigned       k;
            longint unsigned   scaled;
            idx_t              vi;
            idx_t              vj;
            pick_t             p;
            s = picks_per_selection();
            if (draws_done >= s)
                draws_done = 0;
            i = candidates() - 1 - draws_done;
            scaled = (longint'(i + 1) * longint'(word)) / longint'(RAND_LIMIT);
            j = (scaled > i) ? i : int'(scaled);
            vi = entry_set[i] ? perm_value[i] : idx_t'(i);
            vj = entry_set[j] ? perm_value[j] : idx_t'(j);
            perm_value[i] = vj;
            perm_value[j] = vi;
            entry_set[i]  = 1'b1;
            entry_set[j]  = 1'b1;
            // sorted insertion of the value finalized at position i
            k = draws_done;
            while (k > 0 && sorted_so_far[k-1] > vj)
            begin
                sorted_so_far[k] = sorted_so_far[k-1];
                k--;
            end
            sorted_so_far[k] = vj;
            draws_done++;
            if (draws_done >= s)
            begin
                for (int n = 0; n < s; n++)
                begin
                    p.index = sorted_so_far[n];
                    p.last  = (n + 1 == s);
                    expected_picks.insert(expected_picks.size(), p);
                end
                clear_draws();
            end
        endfunction

        function void check_pick(idx_t index, logic last);
            pick_t want;
            if (expected_picks.size() == 0)
            begin
                $display("%0t: unexpected pick index %0d last %0d", $time, index, last);
                errors++;
                return;
            end
            want = expected_picks.pop_front();
            if (index !== want.index)
            begin
                $display("%0t: picked_index expected %0d actual %0d", $time, want.index, index);
                errors++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last_pick expected %0d actual %0d", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [RAND_W-1:0]    random_value;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 pick_strobe;
    idx_t                 picked_index;
    logic                 last_pick;

    sample_tracker tracker;
    int            burst_left;
    int            draws_sent;
    int            quiet_cycles;

    random_sample_without_replacement_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .random_value (random_value),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pick_strobe  (pick_strobe),
        .picked_index (picked_index),
        .last_pick    (last_pick)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // observe every transfer at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pick_strobe)
                tracker.check_pick(picked_index, last_pick);
            if (start && !busy)
                tracker.note_draw(random_value);
            if (cfg_we)
                tracker.write_reg(cfg_index, cfg_data);
        end
    end

    // watchdog on stretches with no transfer at all
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || pick_strobe || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: timeout, no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // mostly uniform words, now and then the ends of the range
    function automatic logic [RAND_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return RAND_TOP;
            2:       return RAND_TOP - 1'b1;
            default: return RAND_W'($urandom());
        endcase
    endfunction

    task automatic idle_cycles(int n);
        start        = 1'b0;
        random_value = RAND_W'($urandom());
        repeat (n) @(negedge clk);
    endtask

    // one draw transfer; the sender runs in bursts with random gaps
    task automatic send_draw(logic [RAND_W-1:0] word);
        bit taken;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 10));
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        start        = 1'b1;
        random_value = word;
        taken        = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
            @(negedge clk);
        end
        draws_sent++;
    endtask

    // hold off until every pick is out and the unit has settled
    task automatic wait_drained();
        start = 1'b0;
        while (tracker.pending() > 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_data  = CFG_W'($urandom());
        repeat (2) @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    task automatic run_selections(int count);
        repeat (count)
            repeat (tracker.picks_per_selection())
                send_draw(pick_word());
    endtask

    // one random phase: new settings, whole selections, maybe a broken one at the end
    task automatic run_phase(logic [CFG_W-1:0] total_data, logic [CFG_W-1:0] select_data,
                             int selections, bit partial);
        int unsigned s;
        if ($urandom_range(0, 1))
        begin
            program_reg(REG_TOTAL_COUNT, total_data);
            program_reg(REG_SELECT_COUNT, select_data);
        end
        else
        begin
            program_reg(REG_SELECT_COUNT, select_data);
            program_reg(REG_TOTAL_COUNT, total_data);
        end
        if ($urandom_range(0, 5) == 0)
            program_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B, CFG_W'($urandom()));
        run_selections(selections);
        s = tracker.picks_per_selection();
        if (partial && s > 1)
            repeat ($urandom_range(1, s - 1))
                send_draw(pick_word());
    endtask

    function automatic logic [CFG_W-1:0] random_total();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_W'($urandom_range(1025, 2047));
            2:       return CFG_W'(MAX_TOTAL);
            3, 4:    return CFG_W'($urandom_range(1, 8));
            default: return CFG_W'($urandom_range(1, MAX_TOTAL));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_select();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_W'($urandom_range(65, 2047));
            2:       return CFG_W'(MAX_SELECT);
            default: return CFG_W'($urandom_range(1, 16));
        endcase
    endfunction

    initial
    begin
        tracker      = new();
        burst_left   = 0;
        draws_sent   = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        random_value = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_TOTAL_COUNT;
        cfg_data     = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        // clearing pass after reset
        @(negedge clk);
        while (busy)
            @(negedge clk);

        // reset settings: one pick out of 1024, field extremes
        send_draw('0);
        send_draw(RAND_TOP);
        send_draw(RAND_W'(1));
        send_draw(RAND_TOP - 1'b1);
        send_draw(RAND_W'(31'h5555_5555));
        send_draw(RAND_W'(31'h2AAA_AAAA));

        // writes to unused indexes change nothing
        program_reg(REG_UNUSED_A, CFG_W'(11'h7FF));
        program_reg(REG_UNUSED_B, CFG_W'(11'h001));
        send_draw(RAND_TOP >> 1);

        // zero total and zero select both act as one
        program_reg(REG_TOTAL_COUNT, '0);
        program_reg(REG_SELECT_COUNT, '0);
        send_draw(RAND_TOP);
        send_draw('0);

        // full permutation, select equal to total
        program_reg(REG_TOTAL_COUNT, CFG_W'(5));
        program_reg(REG_SELECT_COUNT, CFG_W'(5));
        send_draw('0);
        send_draw(RAND_TOP);
        send_draw('0);
        send_draw(RAND_TOP);
        send_draw(RAND_TOP - 1'b1);

        // select above total, with high data bits dropped by the register width
        program_reg(REG_TOTAL_COUNT, CFG_W'(3));
        program_reg(REG_SELECT_COUNT, CFG_W'(11'h0C8));
        run_selections(1);

        // selection abandoned by a register write halfway through
        program_reg(REG_TOTAL_COUNT, CFG_W'(10));
        program_reg(REG_SELECT_COUNT, CFG_W'(4));
        send_draw(pick_word());
        send_draw(pick_word());
        program_reg(REG_SELECT_COUNT, CFG_W'(4));
        run_selections(1);

        // random phases, starting from the largest sizes
        draws_sent = 0;
        run_phase(CFG_W'(11'h7FF), CFG_W'(MAX_SELECT), 1, 1'b0);
        while (draws_sent < RANDOM_DRAWS)
            run_phase(random_total(), random_select(), $urandom_range(1, 3),
                      $urandom_range(0, 2) == 0);

        // drain and report
        start = 1'b0;
        while (tracker.pending() > 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rsmp_pkg.sv
sv/rsmp_cell.sv
sv/random_sample_without_replacement_unit.sv
tb/sv/random_sample_without_replacement_unit_test.sv
